/* rtl/core/audio_block_prefill_queue_assert.svh */
// Assertion helpers used by the checker of this block.
`ifndef AUDIO_BLOCK_PREFILL_QUEUE_ASSERT_SVH
`define AUDIO_BLOCK_PREFILL_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("abpq: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define ABPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("abpq: property violated");

`endif

/* rtl/core/abpq_pkg.sv */
package abpq_pkg;

    // input beat layout
    localparam int ACTION_W   = 3;
    localparam int TAG_FLD_W  = 32;
    localparam int FRAMES_W   = 16;
    localparam int LIMIT_W    = 5;
    localparam int S_TDATA_W  = 56;
    localparam int TAG_LSB    = 0;
    localparam int FRAMES_LSB = 32;
    localparam int LIMIT_LSB  = 48;

    // result beat layout
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 3;

    // config port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 19;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STREAMING_ON = 4'd1;

    // prefill threshold ceil(rate*2/1000) via reciprocal multiply
    localparam int THR_W       = 11;
    localparam int PRE_W       = 21;
    localparam int PROD_W      = 42;
    localparam int RECIP_SHIFT = 30;
    localparam logic [PRE_W-1:0] RECIP_1000 = 21'd1073742;
    localparam logic [PRE_W-1:0] ROUND_UP   = 21'd999;
    localparam logic [THR_W-1:0] THR_RESET  = 11'd96;   // 48 kHz

    localparam int FT_W = 32;
    localparam logic [LIMIT_W-1:0] MAX_DRAIN = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SUBMIT   = 3'd0,
        ACT_TAKE     = 3'd1,
        ACT_COMPLETE = 3'd2,
        ACT_DRAIN    = 3'd3,
        ACT_RESTART  = 3'd4
    } act_e;

    // result flags, tag_valid in bit 0
    typedef struct packed {
        logic starved;
        logic accepted;
        logic tag_valid;
    } res_flags_t;

    typedef struct packed {
        logic             streaming_on;
        logic [THR_W-1:0] thr;
    } cfg_t;

endpackage

/* rtl/core/abpq_slot_ram.sv */
module abpq_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/abpq_cfg.sv */
module abpq_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [abpq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [abpq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output abpq_pkg::cfg_t                  cfg
);

    logic [abpq_pkg::PRE_W-1:0]  pre;
    logic [abpq_pkg::PROD_W-1:0] prod;
    logic [abpq_pkg::THR_W-1:0]  thr_reg, thr_next;
    logic                        stream_reg, stream_next;

    // rate*2 + 999, then divide by 1000 (exact over the whole 19-bit range)
    assign pre  = {1'b0, cfg_wdata, 1'b0} + abpq_pkg::ROUND_UP;
    assign prod = abpq_pkg::PROD_W'(pre) * abpq_pkg::PROD_W'(abpq_pkg::RECIP_1000);

    always_comb begin
        thr_next    = thr_reg;
        stream_next = stream_reg;
        if (cfg_wr_en && cfg_addr == abpq_pkg::REG_SAMPLE_RATE) begin
            thr_next = prod[abpq_pkg::RECIP_SHIFT +: abpq_pkg::THR_W];
        end
        if (cfg_wr_en && cfg_addr == abpq_pkg::REG_STREAMING_ON) begin
            stream_next = cfg_wdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= abpq_pkg::THR_RESET;
            stream_reg <= 1'b0;
        end else begin
            thr_reg    <= thr_next;
            stream_reg <= stream_next;
        end
    end

    assign cfg.streaming_on = stream_reg;
    assign cfg.thr          = thr_reg;

endmodule

/* rtl/core/abpq_ctrl.sv */
module abpq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_W       = 32,
    parameter int PW          = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  abpq_pkg::cfg_t                 cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [abpq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [abpq_pkg::ACTION_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [abpq_pkg::M_TDATA_W-1:0] m_tdata,
    output abpq_pkg::res_flags_t           m_tuser,
    output logic                           m_tlast,
    output logic                           wr_en,
    output logic [PW-1:0]                  wr_addr,
    output logic [TAG_W-1:0]               wr_data,
    output logic [PW-1:0]                  rd_addr,
    input  logic [TAG_W-1:0]               rd_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t                          state_reg, state_next;
    abpq_pkg::act_e                  act_reg, act_next;
    logic [TAG_W-1:0]                tag_reg, tag_next;
    logic [abpq_pkg::FRAMES_W-1:0]   frames_reg, frames_next;
    logic [abpq_pkg::LIMIT_W-1:0]    limit_reg, limit_next;
    logic [abpq_pkg::LIMIT_W-1:0]    rem_reg, rem_next;
    logic [PW-1:0]                   wp_reg, wp_next;
    logic [PW-1:0]                   rp_reg, rp_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [abpq_pkg::FT_W-1:0]       ft_reg, ft_next;
    logic                            pf_reg, pf_next;
    logic                            rec_reg, rec_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [abpq_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    abpq_pkg::res_flags_t            m_tuser_reg, m_tuser_next;
    logic                            m_tlast_reg, m_tlast_next;

    logic                            submit_ok;
    logic                            primed;
    logic                            last_pop;
    logic [abpq_pkg::FT_W:0]         ft_sum;
    logic [abpq_pkg::LIMIT_W-1:0]    eff_limit;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign submit_ok = cfg.streaming_on && (tag_reg != '0) && (cnt_reg < CW'(QUEUE_DEPTH));
    assign primed    = ft_reg >= abpq_pkg::FT_W'(cfg.thr);
    assign ft_sum    = {1'b0, ft_reg} + (abpq_pkg::FT_W + 1)'(frames_reg);
    assign eff_limit = (limit_reg > abpq_pkg::MAX_DRAIN) ? abpq_pkg::MAX_DRAIN : limit_reg;
    assign last_pop  = (rem_reg == abpq_pkg::LIMIT_W'(1)) || (cnt_reg == CW'(1));

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        tag_next      = tag_reg;
        frames_next   = frames_reg;
        limit_next    = limit_reg;
        rem_next      = rem_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        cnt_next      = cnt_reg;
        ft_next       = ft_reg;
        pf_next       = pf_reg;
        rec_next      = rec_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        wr_en         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next    = abpq_pkg::act_e'(s_tuser);
                    tag_next    = s_tdata[abpq_pkg::TAG_LSB +: TAG_W];
                    frames_next = s_tdata[abpq_pkg::FRAMES_LSB +: abpq_pkg::FRAMES_W];
                    limit_next  = s_tdata[abpq_pkg::LIMIT_LSB +: abpq_pkg::LIMIT_W];
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // default: single all-zero result with last set
                m_tvalid_next = 1'b1;
                m_tdata_next  = '0;
                m_tuser_next  = '0;
                m_tlast_next  = 1'b1;
                state_next    = ST_OUT;
                case (act_reg)
                    abpq_pkg::ACT_SUBMIT: begin
                        m_tuser_next.accepted = submit_ok;
                        if (submit_ok) begin
                            wr_en    = 1'b1;
                            wp_next  = ptr_inc(wp_reg);
                            cnt_next = cnt_reg + CW'(1);
                            ft_next  = ft_sum[abpq_pkg::FT_W] ? '1
                                                              : ft_sum[abpq_pkg::FT_W-1:0];
                        end
                    end
                    abpq_pkg::ACT_TAKE: begin
                        if (cfg.streaming_on) begin
                            if (pf_reg && !primed) begin
                                m_tuser_next.starved = rec_reg;
                            end else if (cnt_reg == '0) begin
                                // underrun: arm priming again
                                pf_next              = 1'b1;
                                rec_next             = 1'b1;
                                m_tuser_next.starved = 1'b1;
                            end else begin
                                pf_next                = 1'b0;
                                rec_next               = 1'b0;
                                m_tdata_next           = abpq_pkg::M_TDATA_W'(rd_data);
                                m_tuser_next.tag_valid = 1'b1;
                                rp_next                = ptr_inc(rp_reg);
                                cnt_next               = cnt_reg - CW'(1);
                            end
                            if (pf_reg && primed && cnt_reg == '0) begin
                                pf_next  = 1'b1;
                                rec_next = 1'b1;
                            end
                        end
                    end
                    abpq_pkg::ACT_COMPLETE: begin
                        ft_next = (abpq_pkg::FT_W'(frames_reg) < ft_reg)
                                ? ft_reg - abpq_pkg::FT_W'(frames_reg) : '0;
                    end
                    abpq_pkg::ACT_DRAIN: begin
                        if (cnt_reg == '0 || eff_limit == '0) begin
                            wp_next  = '0;
                            rp_next  = '0;
                            cnt_next = '0;
                            ft_next  = '0;
                            pf_next  = 1'b1;
                            rec_next = 1'b0;
                        end else begin
                            m_tvalid_next = 1'b0;
                            rem_next      = eff_limit;
                            state_next    = ST_DRAIN;
                        end
                    end
                    abpq_pkg::ACT_RESTART: begin
                        wp_next  = '0;
                        rp_next  = '0;
                        cnt_next = '0;
                        ft_next  = '0;
                        pf_next  = 1'b1;
                        rec_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_DRAIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next          = 1'b1;
                    m_tdata_next           = abpq_pkg::M_TDATA_W'(rd_data);
                    m_tuser_next           = '0;
                    m_tuser_next.tag_valid = 1'b1;
                    m_tlast_next           = last_pop;
                    rp_next                = ptr_inc(rp_reg);
                    cnt_next               = cnt_reg - CW'(1);
                    rem_next               = rem_reg - abpq_pkg::LIMIT_W'(1);
                    if (last_pop) begin
                        wp_next    = '0;
                        rp_next    = '0;
                        cnt_next   = '0;
                        ft_next    = '0;
                        pf_next    = 1'b1;
                        rec_next   = 1'b0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            act_reg      <= abpq_pkg::ACT_SUBMIT;
            tag_reg      <= '0;
            frames_reg   <= '0;
            limit_reg    <= '0;
            rem_reg      <= '0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            cnt_reg      <= '0;
            ft_reg       <= '0;
            pf_reg       <= 1'b1;
            rec_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            act_reg      <= act_next;
            tag_reg      <= tag_next;
            frames_reg   <= frames_next;
            limit_reg    <= limit_next;
            rem_reg      <= rem_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            cnt_reg      <= cnt_next;
            ft_reg       <= ft_next;
            pf_reg       <= pf_next;
            rec_reg      <= rec_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    // RAM read follows the next read pointer so its registered output tracks the read pointer
    assign rd_addr  = rp_next;
    assign wr_addr  = wp_reg;
    assign wr_data  = tag_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* rtl/core/audio_block_prefill_queue.sv */
// Each command beat is registered, executed and its result registered and handed off
//   before the next beat is taken. A drain emits one beat per cycle while the result
//   side is not stalled, from the single slot RAM read port.
// Reset (aresetn low, synchronous): queue emptied, frame total zero, priming armed,
//   recovery cleared, sample rate 48000 (threshold 96 frames), streaming off.
//   Slot RAM contents are not cleared; only data from occupied slots is ever used.
module audio_block_prefill_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // config write port: index 0 sample_rate, index 1 streaming_on
    input  logic                            cfg_wr_en,
    input  logic [abpq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [abpq_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // command beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] item_tag, [47:32] frames, [52:48] drain_limit, [55:53] zero
    input  logic [abpq_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] action
    input  logic [abpq_pkg::ACTION_W-1:0]   s_tuser,

    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] out_tag
    output logic [abpq_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] tag_valid, [1] accepted, [2] starved
    output logic [abpq_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);

    // Tags wider than the 32-bit field never carry extra bits, so the
    // stored width is the smaller of the two.
    localparam int TAG_W = (TAG_BITS < abpq_pkg::TAG_FLD_W) ? TAG_BITS : abpq_pkg::TAG_FLD_W;
    localparam int PW    = $clog2(QUEUE_DEPTH);

    abpq_pkg::cfg_t       cfg;
    abpq_pkg::res_flags_t res_flags;

    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    logic [TAG_W-1:0] wr_data;
    logic [PW-1:0]    rd_addr;
    logic [TAG_W-1:0] rd_data;

    // Config registers; the prefill threshold ceil(rate*2/1000) is
    // computed at write time so a take right after a write sees it.
    abpq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Ring of block descriptors, one write and one registered read per cycle.
    abpq_slot_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TAG_W),
        .AW    (PW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: pointers, count, frame accounting, priming gate, drain loop.
    // Each command executes the cycle after its beat; the RAM read for the
    // head slot is issued on the accept edge, so pops need no extra wait.
    abpq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_W       (TAG_W),
        .PW          (PW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (res_flags),
        .m_tlast  (m_tlast),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    assign m_tuser = res_flags;

endmodule

/* rtl/core/abpq_checker.sv */
`include "audio_block_prefill_queue_assert.svh"

module abpq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [abpq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [abpq_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast
);

    // one command in flight: no new beat while a result is pending
    `ABPQ_ASSERT_NOW(a_no_accept_busy, aclk, aresetn, s_tvalid && s_tready, !m_tvalid)

    // command executes the cycle after accept, so input is closed then
    `ABPQ_ASSERT_NEXT(a_closed_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // only drain emits non-final beats, and those always carry a tag
    `ABPQ_ASSERT_NOW(a_untagged_is_last, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast)

    // a stalled result beat holds
    `ABPQ_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind audio_block_prefill_queue abpq_checker u_abpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int QUEUE_DEPTH = 16;
    // action codes the block has no meaning for; they must still answer one beat
    localparam logic [abpq_pkg::ACTION_W-1:0] ACT_FIRST_UNUSED = 3'd5;
    localparam logic [abpq_pkg::ACTION_W-1:0] ACT_LAST_UNUSED  = 3'd7;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [31:0]          tag;
        abpq_pkg::res_flags_t flags;
        logic                 is_last;
    } result_beat_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [abpq_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [abpq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    // [31:0] tag, [47:32] frames, [52:48] limit
    logic [abpq_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [abpq_pkg::ACTION_W-1:0]   s_tuser   = '0;   // [2:0] action
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [abpq_pkg::M_TDATA_W-1:0]  m_tdata;          // [31:0] out_tag
    // [0] tag_valid, [1] accepted, [2] starved
    logic [abpq_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                            m_tlast;

    audio_block_prefill_queue dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 12 ns period
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the jitter buffer: ring, counters, gate flags and
    // the two config registers. Updated at the edge a command beat is
    // accepted; every result beat it implies goes into expected_beats.
    // ---------------------------------------------------------------
    logic [31:0]   ring_tags [QUEUE_DEPTH];
    logic [3:0]    ring_wr;
    logic [3:0]    ring_rd;
    logic [4:0]    ring_count;
    logic [31:0]   held_frames;
    logic          priming;
    logic          recovering;
    logic [18:0]   rate_hz;
    logic          streaming;

    result_beat_t  expected_beats [$];
    int            error_count = 0;
    int            quiet_cycles = 0;
    int            stall_left = 0;
    bit            idle_on = 1'b1;

    function automatic void clear_queue();
        ring_wr     = '0;
        ring_rd     = '0;
        ring_count  = '0;
        held_frames = '0;
        priming     = 1'b1;
        recovering  = 1'b0;
    endfunction

    function automatic void push_result(input logic [31:0] tag, input logic valid,
                                        input logic acc, input logic starve,
                                        input logic is_last);
        result_beat_t b;
        b.tag             = tag;
        b.flags.tag_valid = valid;
        b.flags.accepted  = acc;
        b.flags.starved   = starve;
        b.is_last         = is_last;
        expected_beats.push_back(b);
    endfunction

    task automatic predict_command(input logic [abpq_pkg::ACTION_W-1:0] act,
                                   input logic [31:0] tag,
                                   input logic [15:0] frames,
                                   input logic [abpq_pkg::LIMIT_W-1:0] limit);
        logic [32:0] sum;
        logic [31:0] threshold;
        int          cap;
        int          n_out;
        case (act)
            abpq_pkg::ACT_SUBMIT: begin
                if (streaming && tag != '0 && ring_count < QUEUE_DEPTH) begin
                    ring_tags[ring_wr] = tag;
                    ring_wr    = ring_wr + 1'b1;
                    ring_count = ring_count + 1'b1;
                    // buffered total saturates instead of wrapping
                    sum = {1'b0, held_frames} + {17'd0, frames};
                    held_frames = sum[32] ? '1 : sum[31:0];
                    push_result('0, 1'b0, 1'b1, 1'b0, 1'b1);
                end else begin
                    push_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
                end
            end
            abpq_pkg::ACT_TAKE: begin
                // prefill target: two milliseconds of audio, rounded up
                threshold = ({13'd0, rate_hz} * 2 + 999) / 1000;
                if (!streaming) begin
                    push_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
                end else begin
                    if (priming && held_frames >= threshold) begin
                        priming    = 1'b0;
                        recovering = 1'b0;
                    end
                    if (priming) begin
                        push_result('0, 1'b0, 1'b0, recovering, 1'b1);
                    end else if (ring_count == 0) begin
                        // underrun: re-arm the gate and flag recovery
                        priming    = 1'b1;
                        recovering = 1'b1;
                        push_result('0, 1'b0, 1'b0, 1'b1, 1'b1);
                    end else begin
                        push_result(ring_tags[ring_rd], 1'b1, 1'b0, 1'b0, 1'b1);
                        ring_rd    = ring_rd + 1'b1;
                        ring_count = ring_count - 1'b1;
                    end
                end
            end
            abpq_pkg::ACT_COMPLETE: begin
                held_frames = ({16'd0, frames} < held_frames)
                            ? held_frames - {16'd0, frames} : '0;
                push_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            abpq_pkg::ACT_DRAIN: begin
                cap   = (limit > abpq_pkg::MAX_DRAIN) ? int'(abpq_pkg::MAX_DRAIN) : int'(limit);
                n_out = (int'(ring_count) < cap) ? int'(ring_count) : cap;
                for (int i = 0; i < n_out; i++) begin
                    push_result(ring_tags[ring_rd], 1'b1, 1'b0, 1'b0, i == n_out - 1);
                    ring_rd = ring_rd + 1'b1;
                end
                clear_queue();
                if (n_out == 0)
                    push_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            abpq_pkg::ACT_RESTART: begin
                clear_queue();
                push_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            default: begin
                push_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure, m_tready held low in bursts.
    // One assignment to m_tready per edge.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check the result beat first (it always belongs to an
    // older command), then predict from the command beat of this edge.
    // Also the watchdog.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        result_beat_t got;
        result_beat_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser, m_tlast};
                if (expected_beats.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected: %s %h %b %b",
                                 $time, "tag/flags/last", got.tag, got.flags, got.is_last);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.tag !== want.tag || got.is_last !== want.is_last ||
                        got.flags.tag_valid !== want.flags.tag_valid ||
                        got.flags.accepted !== want.flags.accepted ||
                        got.flags.starved !== want.flags.starved) begin
                        error_count++;
                        // flags print as {starved, accepted, tag_valid}
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: mismatch: expected tag %h flags %b last %b, %s",
                                     $time, want.tag, want.flags, want.is_last,
                                     $sformatf("got tag %h flags %b last %b",
                                               got.tag, got.flags, got.is_last));
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_command(s_tuser,
                                s_tdata[abpq_pkg::TAG_LSB +: abpq_pkg::TAG_FLD_W],
                                s_tdata[abpq_pkg::FRAMES_LSB +: abpq_pkg::FRAMES_W],
                                s_tdata[abpq_pkg::LIMIT_LSB +: abpq_pkg::LIMIT_W]);

            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------
    // Holds tvalid high from one beat to the next unless a gap is drawn.
    task automatic send_command(input logic [abpq_pkg::ACTION_W-1:0] act,
                                input logic [31:0] tag, input logic [15:0] frames,
                                input logic [abpq_pkg::LIMIT_W-1:0] limit);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 12)) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, limit, frames, tag};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and let every outstanding result beat drain out.
    // The first edge lets the monitor log the last accepted command.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [abpq_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] value);
        wait_results_done();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[abpq_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == abpq_pkg::REG_SAMPLE_RATE)
            rate_hz = value[abpq_pkg::CFG_DATA_W-1:0];
        else if (addr == abpq_pkg::REG_STREAMING_ON)
            streaming = value[0];
    endtask

    function automatic logic [31:0] random_tag();
        // zero tag now and then: must be refused
        return ($urandom_range(0, 11) == 0) ? 32'd0 : 32'($urandom);
    endfunction

    function automatic logic [15:0] random_frames();
        // mix of full-range counts and small ones that keep the gate closed longer
        return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                           : 16'($urandom_range(0, 300));
    endfunction

    function automatic logic [abpq_pkg::LIMIT_W-1:0] random_limit();
        return abpq_pkg::LIMIT_W'($urandom_range(0, 31));
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Streaming is off after reset: submit refused, take all zeros,
    // unused action codes answer with a bare last beat.
    task automatic test_reset_defaults();
        send_command(abpq_pkg::ACT_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, 5'h1F);
        send_command(abpq_pkg::ACT_TAKE, 32'hFFFF_FFFF, 16'hFFFF, 5'h1F);
        send_command(ACT_FIRST_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 5'h1F);
        send_command(ACT_LAST_UNUSED, 32'd0, 16'd0, 5'd0);
    endtask

    // 48 kHz: gate opens at 96 frames. Walk through priming, pops,
    // an underrun, and recovery until the gate opens again.
    task automatic test_prefill_gate();
        send_command(abpq_pkg::ACT_SUBMIT, 32'd0, 16'd100, 5'd0);         // zero tag refused
        send_command(abpq_pkg::ACT_SUBMIT, 32'hFFFF_FFFF, 16'd95, 5'd0);  // one frame short
        send_command(abpq_pkg::ACT_TAKE, 32'd0, 16'd0, 5'd0);             // still priming
        send_command(abpq_pkg::ACT_SUBMIT, 32'd1, 16'd1, 5'd0);           // exactly at target
        send_command(abpq_pkg::ACT_TAKE, 32'd0, 16'd0, 5'd0);
        send_command(abpq_pkg::ACT_TAKE, 32'd0, 16'd0, 5'd0);
        send_command(abpq_pkg::ACT_TAKE, 32'd0, 16'd0, 5'd0);             // underrun
        send_command(abpq_pkg::ACT_COMPLETE, 32'd0, 16'hFFFF, 5'd0);      // floors at zero
        send_command(abpq_pkg::ACT_TAKE, 32'd0, 16'd0, 5'd0);             // recovering
        send_command(abpq_pkg::ACT_SUBMIT, 32'h8000_0001, 16'd96, 5'd0);
        send_command(abpq_pkg::ACT_TAKE, 32'd0, 16'd0, 5'd0);             // gate open again
    endtask

    // Fill past depth (last submit refused, pointers wrap), then drain
    // with an oversized limit that clamps to the depth.
    task automatic test_queue_full();
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_command(abpq_pkg::ACT_SUBMIT, 32'h5A00_0000 + i + 1, i[15:0], 5'd0);
        send_command(abpq_pkg::ACT_DRAIN, 32'd0, 16'd0, 5'h1F);
    endtask

    // Mostly well-formed runs (submit batch, then takes or a drain) with
    // random content; the rest single random commands of every kind.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int n;
        int m;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                n = $urandom_range(1, QUEUE_DEPTH + 1);
                repeat (n) send_command(abpq_pkg::ACT_SUBMIT, random_tag(), random_frames(),
                                        random_limit());
                if ($urandom_range(0, 3) == 0) begin
                    m = 1;
                    send_command(abpq_pkg::ACT_DRAIN, $urandom, random_frames(),
                                 random_limit());
                end else begin
                    m = $urandom_range(1, n + 2);
                    repeat (m) send_command(abpq_pkg::ACT_TAKE, $urandom, random_frames(),
                                            random_limit());
                end
                sent += n + m;
            end else begin
                if (pick < 65)
                    send_command(abpq_pkg::ACT_SUBMIT, random_tag(), random_frames(),
                                 random_limit());
                else if (pick < 75)
                    send_command(abpq_pkg::ACT_TAKE, $urandom, random_frames(),
                                 random_limit());
                else if (pick < 84)
                    send_command(abpq_pkg::ACT_COMPLETE, $urandom, random_frames(),
                                 random_limit());
                else if (pick < 90)
                    send_command(abpq_pkg::ACT_DRAIN, $urandom, random_frames(),
                                 random_limit());
                else if (pick < 95)
                    send_command(abpq_pkg::ACT_RESTART, $urandom, random_frames(),
                                 random_limit());
                else
                    send_command(abpq_pkg::ACTION_W'($urandom_range(ACT_FIRST_UNUSED,
                                                                    ACT_LAST_UNUSED)),
                                 $urandom, random_frames(), random_limit());
                sent++;
            end
            // occasionally hold off until the block has answered everything
            if ($urandom_range(0, 19) == 0)
                wait_results_done();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        clear_queue();
        rate_hz   = 19'd48000;
        streaming = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        write_reg(abpq_pkg::REG_STREAMING_ON, 32'd1);
        test_prefill_gate();
        test_queue_full();

        test_random_traffic(50);
        write_reg(abpq_pkg::REG_SAMPLE_RATE, 32'd0);        // gate opens on the first take
        test_random_traffic(40);
        write_reg(abpq_pkg::REG_SAMPLE_RATE, 32'd384000);   // highest target, 768 frames
        test_random_traffic(45);
        write_reg(abpq_pkg::REG_SAMPLE_RATE, $urandom_range(1, 383999));
        test_random_traffic(40);
        write_reg(abpq_pkg::REG_STREAMING_ON, 32'd0);
        test_random_traffic(15);
        write_reg(abpq_pkg::REG_STREAMING_ON, 32'd1);
        write_reg(abpq_pkg::REG_SAMPLE_RATE, 32'd44100);

        // final stretch with no idling on either side
        idle_on = 1'b0;
        test_random_traffic(45);

        wait_results_done();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* audio_block_prefill_queue.f */
+incdir+rtl/core
rtl/core/abpq_pkg.sv
rtl/core/abpq_slot_ram.sv
rtl/core/abpq_cfg.sv
rtl/core/abpq_ctrl.sv
rtl/core/audio_block_prefill_queue.sv
rtl/core/abpq_checker.sv
bench/testbench.sv
